// ===== hw/rtl/ffba_pkg.sv =====
`default_nettype none
package ffba_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int WORD_W     = 64;
    localparam int BIT_W      = 6;
    localparam int MAP_WORDS  = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int WADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IDX_W      = WADDR_W + BIT_W;
    localparam int BLK_W      = 13;
    localparam int OP_W       = 2;
    localparam int ST_W       = 2;
    localparam int DATA_W     = 16;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MARK  = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

    localparam logic [BLK_W-1:0] TOTAL_RESET = 13'd4096;

    typedef struct packed {
        logic               rd_en;
        logic [WADDR_W-1:0] rd_addr;
        logic               wr_en;
        logic [WADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0]  wr_data;
    } t_map_req;

endpackage
`default_nettype wire

// ===== hw/rtl/ffba_scan.sv =====
`default_nettype none
module ffba_scan (
    input  wire logic [ffba_pkg::WORD_W-1:0] i_bits,
    output logic                             o_found,
    output logic [ffba_pkg::BIT_W-1:0]       o_pos
);
    import ffba_pkg::*;

    localparam int GRP   = 8;
    localparam int NGRP  = WORD_W / GRP;

    logic [NGRP-1:0] w_any;
    logic [2:0]      w_low [NGRP];
    logic [2:0]      w_grp;

    // lowest set bit inside each byte
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            w_any[g] = |i_bits[g*GRP +: GRP];
            w_low[g] = 3'd0;
            for (int b = GRP - 1; b >= 0; b--) begin
                if (i_bits[g*GRP + b]) begin
                    w_low[g] = 3'(b);
                end
            end
        end
    end

    // lowest byte that holds a set bit
    always_comb begin
        w_grp = 3'd0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (w_any[g]) begin
                w_grp = 3'(g);
            end
        end
    end

    assign o_found = |w_any;
    assign o_pos   = {w_grp, w_low[w_grp]};

endmodule
`default_nettype wire

// ===== hw/rtl/ffba_map.sv =====
`default_nettype none
module ffba_map (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire ffba_pkg::t_map_req          i_req,
    output logic [ffba_pkg::WORD_W-1:0]      o_rd_data
);
    import ffba_pkg::*;

    logic [WORD_W-1:0]    r_mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] r_vld;
    logic [WORD_W-1:0]    r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    // words never written read as all free
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule
`default_nettype wire

// ===== hw/rtl/first_fit_bitmap_block_allocator_unit.sv =====
// first-fit bitmap block allocator
// requests come in on the s_axis channel: tuser carries the opcode (allocate,
// free, mark used), tdata the 1-based block number for free and mark.
// every request gives exactly one response on m_axis: tdata is the allocated
// block (0 when none), tuser the status (ok, full, out of range).
// the user writes the block count on the cfg channel only while no request is
// pending; the block itself does not enforce this. an allocate scans up to
// 64 map words of 64 bits, one word a cycle, through the priority encoder on
// the single map read port; free and mark read one word, then write it back;
// rejected requests go straight to the response state.
// one request is in flight at a time: a new one is taken the cycle after the
// previous result has moved into the output register.
// reset clears the per-word valid bits, so the whole map reads as free at
// once, and loads the block count with 4096.
// when the receiver stalls, the result holds in the output register and the
// block stops before loading the next result.
`default_nettype none
module first_fit_bitmap_block_allocator_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [12:0] block_number, [15:13] zero
    input  wire logic [ffba_pkg::DATA_W-1:0]   i_s_axis_tdata,
    // [1:0] opcode
    input  wire logic [ffba_pkg::OP_W-1:0]     i_s_axis_tuser,
    output logic                               o_m_axis_tvalid,
    input  wire logic                          i_m_axis_tready,
    // [12:0] allocated_block, [15:13] zero
    output logic [ffba_pkg::DATA_W-1:0]        o_m_axis_tdata,
    // [1:0] status
    output logic [ffba_pkg::ST_W-1:0]          o_m_axis_tuser,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [ffba_pkg::BLK_W-1:0]    i_cfg_data
);
    import ffba_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_RESP
    } t_state;

    t_state             r_state, n_state;
    logic [OP_W-1:0]    r_op, n_op;
    logic [BLK_W-1:0]   r_bn, n_bn;
    logic [WADDR_W:0]   r_word, n_word;
    logic [BLK_W-1:0]   r_blk, n_blk;
    logic [ST_W-1:0]    r_st, n_st;
    logic [BLK_W-1:0]   r_total;
    logic               r_out_valid, n_out_valid;
    logic [BLK_W-1:0]   r_out_blk, n_out_blk;
    logic [ST_W-1:0]    r_out_st, n_out_st;

    t_map_req           w_req;
    logic [WORD_W-1:0]  w_rd_data;
    logic               w_found;
    logic [BIT_W-1:0]   w_pos;

    logic [BLK_W-1:0]   w_limit;
    logic               w_accept;
    logic [OP_W-1:0]    w_in_op;
    logic [BLK_W-1:0]   w_in_bn;
    logic [31:0]        w_in_idx32;
    logic [31:0]        w_bn_idx32;
    logic [IDX_W-1:0]   w_bn_idx;
    logic [IDX_W-1:0]   w_alloc_idx;
    logic [WADDR_W:0]   w_nxt;
    logic [31:0]        w_blk32;

    ffba_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    ffba_scan u_scan (
        .i_bits  (~w_rd_data),
        .o_found (w_found),
        .o_pos   (w_pos)
    );

    assign w_limit = (32'(r_total) > MAX_BLOCKS) ? BLK_W'(MAX_BLOCKS) : r_total;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_op         = i_s_axis_tuser;
    assign w_in_bn         = i_s_axis_tdata[BLK_W-1:0];
    assign w_in_idx32      = 32'(w_in_bn) - 32'd1;
    assign w_bn_idx32      = 32'(r_bn) - 32'd1;
    assign w_bn_idx        = w_bn_idx32[IDX_W-1:0];
    assign w_alloc_idx     = {r_word[WADDR_W-1:0], w_pos};
    assign w_nxt           = r_word + 1'b1;
    assign w_blk32         = 32'(w_alloc_idx) + 32'd1;

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_bn        = r_bn;
        n_word      = r_word;
        n_blk       = r_blk;
        n_st        = r_st;
        n_out_valid = r_out_valid;
        n_out_blk   = r_out_blk;
        n_out_st    = r_out_st;
        w_req       = '0;

        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op  = w_in_op;
                    n_bn  = w_in_bn;
                    n_blk = '0;
                    n_st  = ST_OK;
                    case (w_in_op)
                        OP_ALLOC: begin
                            if (w_limit == '0) begin
                                n_st    = ST_FULL;
                                n_state = S_RESP;
                            end else begin
                                n_word        = '0;
                                w_req.rd_en   = 1'b1;
                                w_req.rd_addr = '0;
                                n_state       = S_SCAN;
                            end
                        end
                        OP_FREE, OP_MARK: begin
                            if (w_in_bn == '0 || w_in_bn > w_limit) begin
                                n_st    = ST_RANGE;
                                n_state = S_RESP;
                            end else begin
                                n_word        = (WADDR_W+1)'(w_in_idx32[IDX_W-1:BIT_W]);
                                w_req.rd_en   = 1'b1;
                                w_req.rd_addr = w_in_idx32[IDX_W-1:BIT_W];
                                n_state       = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_RESP;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                w_req.wr_addr = r_word[WADDR_W-1:0];
                if (r_op == OP_ALLOC) begin
                    if (w_found) begin
                        if (32'(w_alloc_idx) < 32'(w_limit)) begin
                            w_req.wr_en   = 1'b1;
                            w_req.wr_data = w_rd_data | (WORD_W'(1) << w_pos);
                            n_blk         = w_blk32[BLK_W-1:0];
                        end else begin
                            n_st = ST_FULL;
                        end
                        n_state = S_RESP;
                    end else if (32'(w_nxt) >= MAP_WORDS
                                 || (32'(w_nxt) << BIT_W) >= 32'(w_limit)) begin
                        n_st    = ST_FULL;
                        n_state = S_RESP;
                    end else begin
                        n_word        = w_nxt;
                        w_req.rd_en   = 1'b1;
                        w_req.rd_addr = w_nxt[WADDR_W-1:0];
                    end
                end else begin
                    w_req.wr_en = 1'b1;
                    if (r_op == OP_MARK) begin
                        w_req.wr_data = w_rd_data | (WORD_W'(1) << w_bn_idx[BIT_W-1:0]);
                    end else begin
                        w_req.wr_data = w_rd_data & ~(WORD_W'(1) << w_bn_idx[BIT_W-1:0]);
                    end
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_blk   = r_blk;
                    n_out_st    = r_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_total     <= TOTAL_RESET;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_total <= i_cfg_data;
            end
        end
        r_op      <= n_op;
        r_bn      <= n_bn;
        r_word    <= n_word;
        r_blk     <= n_blk;
        r_st      <= n_st;
        r_out_blk <= n_out_blk;
        r_out_st  <= n_out_st;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = DATA_W'(r_out_blk);
    assign o_m_axis_tuser  = r_out_st;

    a_full_no_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_st != ST_OK) |-> (r_out_blk == '0))
        else $error("error status with nonzero block");

    a_scan_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (32'(r_word) < MAP_WORDS))
        else $error("scan word beyond map");

    a_blk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_blk != '0) |-> (r_out_blk <= w_limit))
        else $error("allocated block above block count");

    a_resp_follows_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_op != OP_ALLOC) |=> (r_state == S_RESP))
        else $error("free or mark not finished in one word update");

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import ffba_pkg::*;

    localparam logic [OP_W-1:0] OP_NONE = 2'd3;
    localparam int PAD_W = DATA_W - BLK_W;
    localparam int LONG_STALL = 400;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [BLK_W-1:0] blk_num;
    } blk_request_t;

    typedef struct packed {
        logic [BLK_W-1:0] blk;
        logic [ST_W-1:0]  st;
    } alloc_answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic [DATA_W-1:0] s_tdata = '0;
    logic [OP_W-1:0] s_tuser = '0;
    logic m_tready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [BLK_W-1:0] cfg_data = '0;
    logic s_tready;
    logic m_tvalid;
    logic [DATA_W-1:0] m_tdata;
    logic [ST_W-1:0] m_tuser;
    logic cfg_ready;

    blk_request_t pending_requests[$];
    alloc_answer_t expected_answers[$];
    logic block_used [0:MAX_BLOCKS-1];
    logic [BLK_W-1:0] disk_blocks;
    blk_request_t next_req;
    alloc_answer_t want;

    int snd_idle_pct = 12;
    int rcv_idle_pct = 67;
    int stalls_requested = 0;
    int stalls_served = 0;
    int stall_left = 0;
    int items_queued = 0;
    int results_seen = 0;
    int error_count = 0;
    int n_granted = 0;
    int n_full = 0;
    int n_range = 0;
    int n_cfg = 0;
    int cycle_count = 0;

    first_fit_bitmap_block_allocator_unit u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned usable_blocks(input logic [BLK_W-1:0] count);
        return (count > MAX_BLOCKS) ? MAX_BLOCKS : count;
    endfunction

    function automatic alloc_answer_t run_allocator(input logic [OP_W-1:0] op,
                                                    input logic [BLK_W-1:0] bn);
        int unsigned lim;
        int idx;
        alloc_answer_t ans;
        lim = usable_blocks(disk_blocks);
        ans.blk = '0;
        ans.st = ST_OK;
        idx = -1;
        if (op == OP_ALLOC) begin
            for (int i = 0; i < lim; i++) begin
                if (!block_used[i]) begin
                    idx = i;
                    break;
                end
            end
            if (idx < 0) begin
                ans.st = ST_FULL;
            end else begin
                block_used[idx] = 1'b1;
                ans.blk = BLK_W'(idx + 1);
            end
        end else if (op == OP_FREE || op == OP_MARK) begin
            if (bn == 0 || bn > lim) begin
                ans.st = ST_RANGE;
            end else begin
                block_used[bn - 1] = (op == OP_MARK);
            end
        end
        return ans;
    endfunction

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                next_req = pending_requests.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= {{PAD_W{1'b0}}, next_req.blk_num};
                s_tuser <= next_req.op;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver with an occasional long hold-off
    always @(posedge clk) begin
        if (!rst_n) begin
            m_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stalls_served != stalls_requested) begin
            stalls_served <= stalls_served + 1;
            stall_left <= LONG_STALL;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // monitor and checker
    always @(posedge clk) begin
        if (!rst_n) begin
            disk_blocks = TOTAL_RESET;
            for (int i = 0; i < MAX_BLOCKS; i++) begin
                block_used[i] = 1'b0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                disk_blocks = cfg_data;
                n_cfg++;
            end
            if (s_tvalid && s_tready) begin
                expected_answers.push_back(run_allocator(s_tuser, s_tdata[BLK_W-1:0]));
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_answers.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected transaction: expected none, actual tdata %0d tuser %0d",
                             $time, m_tdata, m_tuser);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_tdata !== {{PAD_W{1'b0}}, want.blk}) begin
                        error_count++;
                        $display("%0t allocated_block mismatch: expected %0d, actual %0d",
                                 $time, want.blk, m_tdata);
                    end
                    if (m_tuser !== want.st) begin
                        error_count++;
                        $display("%0t status mismatch: expected %0d, actual %0d",
                                 $time, want.st, m_tuser);
                    end
                    if (want.st == ST_FULL) begin
                        n_full++;
                    end else if (want.st == ST_RANGE) begin
                        n_range++;
                    end else if (want.blk != 0) begin
                        n_granted++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t timeout with %0d results outstanding", $time, expected_answers.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic push_req(input logic [OP_W-1:0] op, input logic [BLK_W-1:0] bn);
        blk_request_t r;
        r.op = op;
        r.blk_num = bn;
        pending_requests.push_back(r);
        items_queued++;
    endtask

    task automatic wait_drained();
        while (results_seen < items_queued) begin
            @(posedge clk);
        end
    endtask

    task automatic write_block_count(input logic [BLK_W-1:0] value);
        wait_drained();
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do begin
            @(posedge clk);
        end while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_requests(input int n, input int alloc_pct,
                                   input logic [BLK_W-1:0] count);
        int unsigned lim;
        int unsigned top;
        int r;
        logic [OP_W-1:0] op;
        logic [BLK_W-1:0] bn;
        lim = usable_blocks(count);
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(99);
            op = ($urandom_range(1) == 0) ? OP_FREE : OP_MARK;
            // allocations land low, so aim most frees and marks there
            top = (lim > 256 && $urandom_range(1) == 0) ? 256 : lim;
            bn = (top == 0) ? '0 : BLK_W'($urandom_range(top, 1));
            if (r < alloc_pct) begin
                op = OP_ALLOC;
                bn = BLK_W'($urandom);
            end else begin
                r = $urandom_range(99);
                if (r < 55) begin
                    op = OP_FREE;
                end else if (r < 80) begin
                    op = OP_MARK;
                end else if (r < 90) begin
                    bn = ($urandom_range(1) == 0) ? '0 : BLK_W'($urandom_range(8191, lim + 1));
                end else if (r < 95) begin
                    op = OP_NONE;
                    bn = BLK_W'($urandom);
                end else begin
                    bn = BLK_W'($urandom);
                end
            end
            push_req(op, bn);
        end
    endtask

    logic [BLK_W-1:0] phase_count;

    initial begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset count of 4096
        push_req(OP_ALLOC, 13'd8191);
        push_req(OP_ALLOC, 13'd0);
        push_req(OP_FREE, 13'd1);
        push_req(OP_ALLOC, 13'd0);
        push_req(OP_MARK, 13'd4096);
        push_req(OP_MARK, 13'd4097);
        push_req(OP_FREE, 13'd0);
        push_req(OP_FREE, 13'd8191);
        push_req(OP_NONE, 13'd8191);
        push_req(OP_NONE, 13'd0);
        push_req(OP_FREE, 13'd100);
        push_req(OP_MARK, 13'd2);
        push_req(OP_FREE, 13'd4096);
        push_req(OP_ALLOC, 13'd5461);
        push_req(OP_MARK, 13'd5461);
        push_req(OP_MARK, 13'd2730);

        // no blocks at all
        write_block_count(13'd0);
        push_req(OP_ALLOC, 13'd0);
        push_req(OP_FREE, 13'd1);
        push_req(OP_MARK, 13'd1);

        // count above the map size
        write_block_count(13'd8191);
        push_req(OP_MARK, 13'd4096);
        push_req(OP_FREE, 13'd4096);
        push_req(OP_MARK, 13'd4097);

        // single block, shrunk below used bits
        write_block_count(13'd1);
        push_req(OP_ALLOC, 13'd0);
        push_req(OP_FREE, 13'd1);
        push_req(OP_ALLOC, 13'd0);

        write_block_count(13'd64);
        random_requests(120, 55, 13'd64);
        write_block_count(13'd8191);
        random_requests(100, 50, 13'd8191);
        write_block_count(13'd1);
        random_requests(40, 40, 13'd1);

        phase_count = BLK_W'($urandom_range(200, 65));
        write_block_count(phase_count);
        random_requests(75, 55, phase_count);
        wait_drained();
        random_requests(75, 55, phase_count);

        wait_drained();
        snd_idle_pct = 67;
        rcv_idle_pct = 12;
        write_block_count(13'd300);
        random_requests(150, 55, 13'd300);
        write_block_count(13'd0);
        random_requests(20, 50, 13'd0);
        phase_count = BLK_W'($urandom_range(63, 2));
        write_block_count(phase_count);
        random_requests(150, 50, phase_count);

        wait_drained();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        write_block_count(13'd4096);
        stalls_requested = stalls_requested + 1;
        random_requests(150, 50, 13'd4096);
        write_block_count(13'd130);
        random_requests(245, 45, 13'd130);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_answers.size() != 0) begin
            error_count++;
            $display("%0t %0d expected results never arrived", $time, expected_answers.size());
        end
        $display("%0d requests checked over %0d block count writes", results_seen, n_cfg);
        $display("granted %0d, full %0d, out of range %0d", n_granted, n_full, n_range);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
